// ===== hw/rtl/edf_pkg.sv =====
// Shared types and constants for the EDF task scheduler.
package edf_pkg;

	typedef enum logic [2:0] {
		REQ_CREATE    = 3'd0,
		REQ_TERMINATE = 3'd1,
		REQ_SLEEP     = 3'd2,
		REQ_DEADLINE  = 3'd3,
		REQ_TICK      = 3'd4,
		REQ_SET_TICKS = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_REFUSED = 2'd2
	} status_t;

	localparam int unsigned REQ_W   = 3;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned SLOT_W  = 4;
	localparam int unsigned STAT_W  = 2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture request
		logic pick_free;  // claim lowest free slot for the captured request
		logic pop_ready;  // remove ready head into the work slot
		logic pop_sleep;  // remove sleep head into the work slot
		logic free_slot;  // release the work slot
		logic set_dl;     // write deadline of work slot
		logic set_wake;   // write wake tick of work slot
		logic tick_inc;
		logic tick_set;
		logic ins_start;  // begin sorted insert of the work slot
		logic ins_sleep;  // insert targets the sleep queue
		logic ins_step;   // advance the insert walk by one entry
		logic set_status_full;
		logic set_status_ref;
		logic set_new;
	} edf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic free_ok;      // a free slot exists and the ready queue has room
		logic head_idle;    // ready head is the idle task
		logic sleep_full;
		logic sleeper_due;  // sleep head is due and the ready queue has room
		logic ins_done;     // insert walk has placed the entry
	} edf_stat_t;

endpackage

// ===== hw/rtl/edf_if.sv =====
// Valid/ready channel interface carrying a payload.
interface edf_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/edf_datapath.sv =====
// Task tables, ordered queues and the tick counter of the EDF scheduler.
module edf_datapath #(
	parameter int unsigned MaxTasks = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  edf_pkg::edf_cmd_t                cmd,
	input  logic [edf_pkg::REQ_W-1:0]        req_in,
	input  logic [edf_pkg::VALUE_W-1:0]      value_in,
	output edf_pkg::edf_stat_t               stat,
	output logic [edf_pkg::REQ_W-1:0]        req,
	output logic [edf_pkg::SLOT_W-1:0]       running_task,
	output logic [edf_pkg::SLOT_W-1:0]       new_task,
	output logic [edf_pkg::STAT_W-1:0]       status,
	output logic [edf_pkg::VALUE_W-1:0]      tick_now
);
	localparam int unsigned IdxW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
	localparam int unsigned CntW = $clog2(MaxTasks + 1);
	localparam logic [CntW-1:0] MaxCnt = CntW'(MaxTasks);

	logic [IdxW-1:0]            ready_q [MaxTasks];
	logic [IdxW-1:0]            sleep_q [MaxTasks];
	logic [edf_pkg::VALUE_W-1:0] dl_q   [MaxTasks];
	logic [edf_pkg::VALUE_W-1:0] wake_q [MaxTasks];
	logic [MaxTasks-1:0]        used_q;
	logic [CntW-1:0]            rcnt_q, scnt_q, pos_q;
	logic [IdxW-1:0]            work_q, free_idx;
	logic                       free_any, ins_sleep_q, ins_run_q;
	logic [edf_pkg::VALUE_W-1:0] tick_q, value_q, key;
	logic [edf_pkg::REQ_W-1:0]  req_q;
	logic [edf_pkg::SLOT_W-1:0] new_q;
	logic [edf_pkg::STAT_W-1:0] status_q;
	logic [IdxW-1:0]            ent;
	logic [CntW-1:0]            qcnt;
	logic                       stop;

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = MaxTasks - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_any = 1'b1;
				free_idx = IdxW'(i);
			end
		end
	end

	// Insert walk: the entry at pos_q is compared against the work slot key.
	always_comb begin
		qcnt = ins_sleep_q ? scnt_q : rcnt_q;
		key  = ins_sleep_q ? wake_q[work_q] : dl_q[work_q];
		ent  = ins_sleep_q ? sleep_q[pos_q[IdxW-1:0]] : ready_q[pos_q[IdxW-1:0]];
		stop = (pos_q == qcnt) ||
			((ins_sleep_q ? wake_q[ent] : dl_q[ent]) > key);
	end

	assign stat.free_ok     = free_any && (rcnt_q < MaxCnt);
	assign stat.head_idle   = (ready_q[0] == '0);
	assign stat.sleep_full  = (scnt_q >= MaxCnt);
	assign stat.sleeper_due = (scnt_q != '0) && (rcnt_q < MaxCnt) &&
		(wake_q[sleep_q[0]] <= tick_q);
	assign stat.ins_done    = !ins_run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= MaxTasks'(1);
			rcnt_q      <= CntW'(1);
			scnt_q      <= '0;
			tick_q      <= '0;
			ins_run_q   <= 1'b0;
			ins_sleep_q <= 1'b0;
			pos_q       <= '0;
			work_q      <= '0;
			req_q       <= '0;
			new_q       <= '0;
			status_q    <= '0;
			value_q     <= '0;
			for (int i = 0; i < MaxTasks; i++) begin
				ready_q[i] <= '0;
				dl_q[i]    <= {edf_pkg::VALUE_W{i == 0}};
			end
		end else begin
			if (cmd.load) begin
				req_q    <= req_in;
				value_q  <= value_in;
				new_q    <= '0;
				status_q <= edf_pkg::ST_OK;
			end
			if (cmd.set_status_full) status_q <= edf_pkg::ST_FULL;
			if (cmd.set_status_ref) status_q <= edf_pkg::ST_REFUSED;
			if (cmd.pick_free) begin
				work_q         <= free_idx;
				used_q[free_idx] <= 1'b1;
				dl_q[free_idx] <= value_q;
			end
			if (cmd.set_new) new_q <= edf_pkg::SLOT_W'(work_q);
			if (cmd.pop_ready) begin
				work_q <= ready_q[0];
				for (int i = 0; i < MaxTasks - 1; i++) ready_q[i] <= ready_q[i+1];
				rcnt_q <= rcnt_q - CntW'(1);
			end
			if (cmd.pop_sleep) begin
				work_q <= sleep_q[0];
				for (int i = 0; i < MaxTasks - 1; i++) sleep_q[i] <= sleep_q[i+1];
				scnt_q <= scnt_q - CntW'(1);
			end
			if (cmd.free_slot) used_q[work_q] <= 1'b0;
			if (cmd.set_dl) dl_q[work_q] <= value_q;
			if (cmd.set_wake) wake_q[work_q] <= tick_q + value_q;
			if (cmd.tick_inc) tick_q <= tick_q + 1'b1;
			if (cmd.tick_set) tick_q <= value_q;
			if (cmd.ins_start) begin
				ins_run_q   <= 1'b1;
				ins_sleep_q <= cmd.ins_sleep;
				pos_q       <= '0;
			end
			if (cmd.ins_step && ins_run_q) begin
				if (stop) begin
					ins_run_q <= 1'b0;
					for (int i = MaxTasks - 1; i > 0; i--) begin
						if (CntW'(i) > pos_q && CntW'(i) <= qcnt) begin
							if (ins_sleep_q) sleep_q[i] <= sleep_q[i-1];
							else ready_q[i] <= ready_q[i-1];
						end
					end
					if (ins_sleep_q) begin
						sleep_q[pos_q[IdxW-1:0]] <= work_q;
						scnt_q <= scnt_q + CntW'(1);
					end else begin
						ready_q[pos_q[IdxW-1:0]] <= work_q;
						rcnt_q <= rcnt_q + CntW'(1);
					end
				end else begin
					pos_q <= pos_q + CntW'(1);
				end
			end
		end
	end

	assign req          = req_q;
	assign running_task = edf_pkg::SLOT_W'(ready_q[0]);
	assign new_task     = new_q;
	assign status       = status_q;
	assign tick_now     = tick_q;

`ifndef SYNTHESIS
	a_queue_total: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, rcnt_q} + {1'b0, scnt_q}) <= {1'b0, MaxCnt}) else $error("too many queued tasks");
	a_idle_used: assert property (@(posedge clk) disable iff (!arst_n)
		used_q[0]) else $error("idle slot released");
	a_rcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= MaxCnt && scnt_q <= MaxCnt) else $error("queue count overflow");
`endif
endmodule

// ===== hw/rtl/edf_ctrl.sv =====
// Request sequencer of the EDF scheduler.
module edf_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  logic                      out_ready,
	input  logic [edf_pkg::REQ_W-1:0] req,
	input  edf_pkg::edf_stat_t        stat,
	output edf_pkg::edf_cmd_t         cmd
);
	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_PREP   = 6'b000100,
		S_INSERT = 6'b001000,
		S_WAKE   = 6'b010000,
		S_OUT    = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   sleep_ins_q, sleep_ins_d;

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		sleep_ins_d = sleep_ins_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_OUT;
				case (req)
					edf_pkg::REQ_CREATE: begin
						if (stat.free_ok) begin
							cmd.pick_free = 1'b1;
							sleep_ins_d   = 1'b0;
							state_d       = S_PREP;
						end else begin
							cmd.set_status_full = 1'b1;
						end
					end
					edf_pkg::REQ_TERMINATE: begin
						if (stat.head_idle) cmd.set_status_ref = 1'b1;
						else begin
							cmd.pop_ready = 1'b1;
							state_d       = S_PREP;
						end
					end
					edf_pkg::REQ_SLEEP: begin
						if (stat.head_idle || stat.sleep_full) cmd.set_status_ref = 1'b1;
						else begin
							cmd.pop_ready = 1'b1;
							sleep_ins_d   = 1'b1;
							state_d       = S_PREP;
						end
					end
					edf_pkg::REQ_DEADLINE: begin
						cmd.pop_ready = 1'b1;
						sleep_ins_d   = 1'b0;
						state_d       = S_PREP;
					end
					edf_pkg::REQ_TICK: begin
						cmd.tick_inc = 1'b1;
						state_d      = S_WAKE;
					end
					edf_pkg::REQ_SET_TICKS: cmd.tick_set = 1'b1;
					default: ;
				endcase
			end
			S_PREP: begin
				case (req)
					edf_pkg::REQ_CREATE: begin
						cmd.set_new   = 1'b1;
						cmd.ins_start = 1'b1;
						state_d       = S_INSERT;
					end
					edf_pkg::REQ_TERMINATE: begin
						cmd.free_slot = 1'b1;
						state_d       = S_OUT;
					end
					edf_pkg::REQ_SLEEP: begin
						cmd.set_wake  = 1'b1;
						state_d       = S_PREP;
						sleep_ins_d   = 1'b0;
						if (!sleep_ins_q) begin
							cmd.set_wake  = 1'b0;
							cmd.ins_start = 1'b1;
							cmd.ins_sleep = 1'b1;
							state_d       = S_INSERT;
						end
					end
					edf_pkg::REQ_DEADLINE: begin
						cmd.set_dl = 1'b1;
						state_d    = S_PREP;
						sleep_ins_d = 1'b1;
						if (sleep_ins_q) begin
							cmd.set_dl    = 1'b0;
							cmd.ins_start = 1'b1;
							state_d       = S_INSERT;
						end
					end
					edf_pkg::REQ_TICK: begin
						cmd.ins_start = 1'b1;
						state_d       = S_INSERT;
					end
					default: state_d = S_OUT;
				endcase
			end
			S_INSERT: begin
				cmd.ins_step = 1'b1;
				if (stat.ins_done) state_d = (req == edf_pkg::REQ_TICK) ? S_WAKE : S_OUT;
			end
			S_WAKE: begin
				if (stat.sleeper_due) begin
					cmd.pop_sleep = 1'b1;
					state_d       = S_PREP;
				end else begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sleep_ins_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			sleep_ins_q <= sleep_ins_d;
		end
	end

`ifndef SYNTHESIS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("accept while result pending");
	a_insert_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_start |=> state_q == S_INSERT) else $error("insert not started");
`endif
endmodule

// ===== hw/rtl/edf_task_scheduler.sv =====
// Top level of the earliest-deadline-first task scheduler.
// A request is decoded and prepared; a create, sleep or deadline change then walks its queue to
// insert the task in order, and a tick wakes each due sleeper the same way. The next request is
// taken only after the response has been transferred.
// Asynchronous active-low reset installs the idle task in slot 0 with the greatest deadline.
module edf_task_scheduler #(
	parameter int unsigned MAX_TASKS = 16
) (
	input logic clk,
	input logic arst_n,
	edf_if.sink   req_ch,
	edf_if.source rsp_ch
);
	edf_pkg::edf_cmd_t  cmd;
	edf_pkg::edf_stat_t stat;
	logic [edf_pkg::REQ_W-1:0] req;

	edf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_ch.valid),
		.in_ready  (req_ch.ready),
		.out_valid (rsp_ch.valid),
		.out_ready (rsp_ch.ready),
		.req       (req),
		.stat      (stat),
		.cmd       (cmd)
	);

	edf_datapath #(.MaxTasks(MAX_TASKS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req_in       (req_ch.payload.req_type),
		.value_in     (req_ch.payload.value),
		.stat         (stat),
		.req          (req),
		.running_task (rsp_ch.payload.running_task),
		.new_task     (rsp_ch.payload.new_task),
		.status       (rsp_ch.payload.status),
		.tick_now     (rsp_ch.payload.tick_now)
	);
endmodule
